[design/jlg_pkg.sv]
// Shared types, constants and codes for the Jacobi Laplace grid solver.
`timescale 1ns / 1ps

package jlg_pkg;

	// Default grid capacity (cells per side)
	localparam int MAX_GRID_DEF = 128;

	// Field widths
	localparam int CELL_W     = 29;
	localparam int SWEEP_W    = 24;
	localparam int SIDE_W     = 8;
	localparam int CI_W       = 8;
	localparam int RC_IN_W    = 7;
	localparam int OP_W       = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 29;
	localparam int FRAC_BITS  = 24;

	// Edge interpolation: every edge spans 10.0, so one dividend serves all four
	localparam int SPAN_W = 28;
	localparam logic [SPAN_W-1:0] EDGE_SPAN = SPAN_W'(32'd10 << FRAC_BITS);

	// Corner values and interior fill, Q5.24
	localparam logic [CELL_W-1:0] CORNER_TL = CELL_W'(32'd10 << FRAC_BITS);
	localparam logic [CELL_W-1:0] CORNER_TR = CELL_W'(32'd20 << FRAC_BITS);
	localparam logic [CELL_W-1:0] CORNER_BL = CELL_W'(32'd20 << FRAC_BITS);
	localparam logic [CELL_W-1:0] FILL_MEAN = CELL_W'(((32'd10 + 32'd20 + 32'd20 + 32'd30) / 4)
		<< FRAC_BITS);

	// Register reset values
	localparam logic [SIDE_W-1:0]  GRID_SIZE_RST = SIDE_W'(10);
	localparam logic [SWEEP_W-1:0] MAX_ITER_RST  = SWEEP_W'(1000000);
	localparam logic [CELL_W-1:0]  TOL_RST       = CELL_W'(17);
	localparam logic [CI_W-1:0]    CI_RST        = CI_W'(70);

	// Operation codes
	typedef enum logic [OP_W-1:0] {
		OP_INIT  = 2'd0,
		OP_SOLVE = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRID_SIZE      = 3'd0,
		REG_MAX_ITERATIONS = 3'd1,
		REG_TOLERANCE      = 3'd2,
		REG_INIT_MEAN      = 3'd3,
		REG_CHECK_INTERVAL = 3'd4
	} cfg_reg_t;

	// Effective settings handed to the engine
	typedef struct packed {
		logic [SIDE_W-1:0]  side;
		logic [SWEEP_W-1:0] limit;
		logic [CELL_W-1:0]  tolerance;
		logic               init_mean;
		logic [CI_W-1:0]    check_interval;
	} cfg_t;

	// One command item
	typedef struct packed {
		op_t                op;
		logic [RC_IN_W-1:0] row;
		logic [RC_IN_W-1:0] col;
	} cmd_t;

	// Per-item result from the engine
	typedef struct packed {
		logic [CELL_W-1:0] cell_value;
		logic              status;
	} res_t;

endpackage

[design/jlg_ram.sv]
// Single-port-write, single-port-read grid bank with registered read data.
`timescale 1ns / 1ps

module jlg_ram #(
	parameter int DEPTH  = jlg_pkg::MAX_GRID_DEF * jlg_pkg::MAX_GRID_DEF,
	parameter int WIDTH  = jlg_pkg::CELL_W,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one entry, read one entry; read data is registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[design/jlg_div.sv]
// Restoring divider for the edge step: EDGE_SPAN divided by the grid's last index.
`timescale 1ns / 1ps

module jlg_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [jlg_pkg::SIDE_W-1:0]    divisor,
	output logic                          done,
	output logic [jlg_pkg::SPAN_W-1:0]    quot,
	output logic [jlg_pkg::SIDE_W-1:0]    rem
);

	localparam int CNT_W = $clog2(jlg_pkg::SPAN_W + 1);

	logic [jlg_pkg::SPAN_W-1:0] quot_q;
	logic [jlg_pkg::SIDE_W-1:0] rem_q;
	logic [jlg_pkg::SIDE_W-1:0] dvs_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [jlg_pkg::SIDE_W:0]   shifted;
	logic [jlg_pkg::SIDE_W:0]   diff;
	logic                       ge;

	// One quotient bit per cycle
	always_comb begin
		shifted = {rem_q, quot_q[jlg_pkg::SPAN_W-1]};
		ge      = shifted >= {1'b0, dvs_q};
		diff    = shifted - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(jlg_pkg::SPAN_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= jlg_pkg::EDGE_SPAN;
			rem_q  <= '0;
			dvs_q  <= divisor;
		end else if (busy_q) begin
			quot_q <= {quot_q[jlg_pkg::SPAN_W-2:0], ge};
			rem_q  <= ge ? diff[jlg_pkg::SIDE_W-1:0] : shifted[jlg_pkg::SIDE_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;

endmodule

[design/jlg_engine.sv]
// Sequencer for init, Jacobi sweeps and cell reads over the two grid banks.
`timescale 1ns / 1ps

module jlg_engine #(
	parameter int MAX_GRID = jlg_pkg::MAX_GRID_DEF,
	parameter int ADDR_W   = $clog2(MAX_GRID * MAX_GRID)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  jlg_pkg::cfg_t                 cfg,
	input  logic                          cmd_valid,
	output logic                          cmd_ready,
	input  jlg_pkg::cmd_t                 cmd,
	output logic                          res_valid,
	input  logic                          res_ready,
	output jlg_pkg::res_t                 res,
	output logic [jlg_pkg::SWEEP_W-1:0]   last_sweeps,
	output logic [jlg_pkg::CELL_W-1:0]    last_error,
	output logic [ADDR_W-1:0]             mem_raddr,
	input  logic [jlg_pkg::CELL_W-1:0]    rdata_a,
	input  logic [jlg_pkg::CELL_W-1:0]    rdata_b,
	output logic [ADDR_W-1:0]             mem_waddr,
	output logic [jlg_pkg::CELL_W-1:0]    mem_wdata,
	output logic                          we_a,
	output logic                          we_b
);

	localparam int RC_W  = (MAX_GRID > 1) ? $clog2(MAX_GRID) : 1;
	localparam int CW    = jlg_pkg::CELL_W;
	localparam int SW    = jlg_pkg::SIDE_W;
	localparam int ACC_W = CW + 2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_FILL,
		S_SW,
		S_SW_END,
		S_RD_ISSUE,
		S_RD_DATA,
		S_DONE
	} state_t;

	state_t                       state_q;
	logic [RC_W-1:0]              r_q;
	logic [RC_W-1:0]              c_q;
	logic [2:0]                   ph_q;
	logic                         cur_q;
	logic [jlg_pkg::SWEEP_W-1:0]  sweeps_q;
	logic [jlg_pkg::CI_W-1:0]     since_q;
	logic [CW-1:0]                maxchg_q;
	logic [ACC_W-1:0]             acc_q;
	logic [CW-1:0]                ctr_q;
	logic [CW-1:0]                diff_q;
	logic [SW-1:0]                d_q;
	logic [jlg_pkg::SPAN_W-1:0]   kq_q;
	logic [SW-1:0]                kr_q;
	logic [CW-1:0]                qc_q;
	logic [SW-1:0]                remc_q;
	logic [CW-1:0]                qr_q;
	logic [SW-1:0]                remr_q;
	logic [jlg_pkg::SWEEP_W-1:0]  last_sweeps_q;
	logic [CW-1:0]                last_error_q;
	jlg_pkg::res_t                res_q;
	jlg_pkg::cmd_t                cmd_q;

	logic                         div_start;
	logic                         div_done;
	logic [jlg_pkg::SPAN_W-1:0]   div_quot;
	logic [SW-1:0]                div_rem;

	logic [CW-1:0]                src;
	logic [CW-1:0]                newv;
	logic [CW-1:0]                fill_val;
	logic                         in_grid;
	logic [SW:0]                  sum_c;
	logic [SW:0]                  sum_r;
	logic                         wrap_c;
	logic                         wrap_r;
	logic [jlg_pkg::SWEEP_W-1:0]  sweeps_n;
	logic                         chk;
	logic                         stop;
	logic                         in_range;
	logic [SW-1:0]                side_m1;

	jlg_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.divisor (side_m1),
		.done    (div_done),
		.quot    (div_quot),
		.rem     (div_rem)
	);

	function automatic logic [ADDR_W-1:0] addr_of(input logic [RC_W-1:0] rr,
		input logic [RC_W-1:0] cc);
		addr_of = ADDR_W'(int'(rr) * MAX_GRID + int'(cc));
	endfunction

	// Source bank data and per-cell arithmetic
	always_comb begin
		src      = cur_q ? rdata_b : rdata_a;
		newv     = acc_q[ACC_W-1:2];
		side_m1  = cfg.side - SW'(1);
		sum_c    = {1'b0, remc_q} + {1'b0, kr_q};
		sum_r    = {1'b0, remr_q} + {1'b0, kr_q};
		wrap_c   = sum_c >= {1'b0, d_q};
		wrap_r   = sum_r >= {1'b0, d_q};
		sweeps_n = sweeps_q + jlg_pkg::SWEEP_W'(1);
		chk      = since_q >= cfg.check_interval;
		stop     = (chk && (maxchg_q <= cfg.tolerance)) || (sweeps_n >= cfg.limit);
		in_range = (int'(cmd.row) < int'(cfg.side)) && (int'(cmd.col) < int'(cfg.side));
	end

	// Init value of the entry at the fill pointer
	always_comb begin
		in_grid = (int'(r_q) <= int'(d_q)) && (int'(c_q) <= int'(d_q));
		if (!in_grid) begin
			fill_val = '0;
		end else if (r_q == '0) begin
			fill_val = jlg_pkg::CORNER_TL + qc_q;
		end else if (int'(r_q) == int'(d_q)) begin
			fill_val = jlg_pkg::CORNER_BL + qc_q;
		end else if (c_q == '0) begin
			fill_val = jlg_pkg::CORNER_TL + qr_q;
		end else if (int'(c_q) == int'(d_q)) begin
			fill_val = jlg_pkg::CORNER_TR + qr_q;
		end else begin
			fill_val = cfg.init_mean ? jlg_pkg::FILL_MEAN : '0;
		end
	end

	// Memory port drive
	always_comb begin
		mem_raddr = addr_of(r_q, c_q);
		mem_waddr = addr_of(r_q, c_q);
		mem_wdata = newv;
		we_a      = 1'b0;
		we_b      = 1'b0;
		unique case (state_q)
			S_FILL: begin
				mem_wdata = fill_val;
				we_a      = 1'b1;
				we_b      = 1'b1;
			end
			S_SW: begin
				case (ph_q)
					3'd0:    mem_raddr = addr_of(r_q - RC_W'(1), c_q);
					3'd1:    mem_raddr = addr_of(r_q, c_q - RC_W'(1));
					3'd3:    mem_raddr = addr_of(r_q, c_q + RC_W'(1));
					3'd4:    mem_raddr = addr_of(r_q + RC_W'(1), c_q);
					default: mem_raddr = addr_of(r_q, c_q);
				endcase
				if (ph_q == 3'd6) begin
					we_a = cur_q;
					we_b = !cur_q;
				end
			end
			S_RD_ISSUE: mem_raddr = addr_of(RC_W'(cmd_q.row), RC_W'(cmd_q.col));
			default: ;
		endcase
	end

	assign div_start = (state_q == S_IDLE) && cmd_valid && (cmd.op == jlg_pkg::OP_INIT);

	// Sequencer state and registered results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			cur_q         <= 1'b0;
			last_sweeps_q <= '0;
			last_error_q  <= '0;
			ph_q          <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						cmd_q <= cmd;
						d_q   <= side_m1;
						unique case (cmd.op)
							jlg_pkg::OP_INIT: state_q <= S_DIV;
							jlg_pkg::OP_SOLVE: begin
								sweeps_q <= '0;
								since_q  <= '0;
								maxchg_q <= '0;
								r_q      <= RC_W'(1);
								c_q      <= RC_W'(1);
								ph_q     <= '0;
								state_q  <= S_SW;
							end
							jlg_pkg::OP_READ: begin
								if (in_range) begin
									state_q <= S_RD_ISSUE;
								end else begin
									res_q   <= '{cell_value: '0, status: 1'b1};
									state_q <= S_DONE;
								end
							end
							default: begin
								res_q   <= '{cell_value: '0, status: 1'b0};
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_DIV: begin
					if (div_done) begin
						kq_q    <= div_quot;
						kr_q    <= div_rem;
						r_q     <= '0;
						c_q     <= '0;
						qc_q    <= '0;
						qr_q    <= '0;
						remc_q  <= d_q >> 1;
						remr_q  <= d_q >> 1;
						state_q <= S_FILL;
					end
				end
				S_FILL: begin
					// Walk every entry; column step restarts each row
					if (int'(c_q) == MAX_GRID - 1) begin
						c_q    <= '0;
						qc_q   <= '0;
						remc_q <= d_q >> 1;
						qr_q   <= qr_q + CW'(kq_q) + CW'(wrap_r);
						remr_q <= wrap_r ? SW'(sum_r - {1'b0, d_q}) : SW'(sum_r);
						if (int'(r_q) == MAX_GRID - 1) begin
							cur_q   <= 1'b0;
							res_q   <= '{cell_value: '0, status: 1'b0};
							state_q <= S_DONE;
						end else begin
							r_q <= r_q + RC_W'(1);
						end
					end else begin
						c_q    <= c_q + RC_W'(1);
						qc_q   <= qc_q + CW'(kq_q) + CW'(wrap_c);
						remc_q <= wrap_c ? SW'(sum_c - {1'b0, d_q}) : SW'(sum_c);
					end
				end
				S_SW: begin
					ph_q <= ph_q + 3'd1;
					case (ph_q)
						3'd1: acc_q <= ACC_W'(src);
						3'd2: acc_q <= acc_q + ACC_W'(src);
						3'd3: ctr_q <= src;
						3'd4: acc_q <= acc_q + ACC_W'(src);
						3'd5: acc_q <= acc_q + ACC_W'(src);
						3'd6: diff_q <= (newv > ctr_q) ? newv - ctr_q : ctr_q - newv;
						3'd7: begin
							if (diff_q > maxchg_q) begin
								maxchg_q <= diff_q;
							end
							// Advance over the interior
							if (int'(c_q) == int'(d_q) - 1) begin
								c_q <= RC_W'(1);
								if (int'(r_q) == int'(d_q) - 1) begin
									state_q <= S_SW_END;
								end else begin
									r_q <= r_q + RC_W'(1);
								end
							end else begin
								c_q <= c_q + RC_W'(1);
							end
						end
						default: ;
					endcase
				end
				S_SW_END: begin
					cur_q <= !cur_q;
					if (stop) begin
						last_sweeps_q <= sweeps_n;
						last_error_q  <= maxchg_q;
						res_q         <= '{cell_value: '0, status: 1'b0};
						state_q       <= S_DONE;
					end else begin
						since_q  <= chk ? '0 : since_q + jlg_pkg::CI_W'(1);
						sweeps_q <= sweeps_n;
						maxchg_q <= '0;
						r_q      <= RC_W'(1);
						c_q      <= RC_W'(1);
						ph_q     <= '0;
						state_q  <= S_SW;
					end
				end
				S_RD_ISSUE: state_q <= S_RD_DATA;
				S_RD_DATA: begin
					res_q   <= '{cell_value: src, status: 1'b0};
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign cmd_ready   = (state_q == S_IDLE);
	assign res_valid   = (state_q == S_DONE);
	assign res         = res_q;
	assign last_sweeps = last_sweeps_q;
	assign last_error  = last_error_q;

	// Both banks written together only while filling
	a_dual_write: assert property (@(posedge clk) disable iff (!arst_n)
		(we_a && we_b) |-> (state_q == S_FILL))
		else $error("both banks written outside init");

	// A sweep never writes the bank it reads
	a_dst_bank: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_SW) && (we_a || we_b)) |-> (we_a == cur_q))
		else $error("sweep wrote the source bank");

	// A solve never runs past its limit
	a_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SW_END) |-> (sweeps_q < cfg.limit))
		else $error("sweep count beyond limit");

	// Held result stays put until taken
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(res)))
		else $error("result dropped while stalled");

	// Divider answers only during init
	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("divider finished outside init");

endmodule

[design/jacobi_laplace_grid_solver.sv]
// Top level of the Jacobi Laplace grid solver: ports, registers, banks and output stage.
`timescale 1ns / 1ps
//
// Commands arrive on the s_ stream: s_tuser carries the operation (init, solve,
// read), s_tdata the row and column of a read. Each command yields one item on
// the m_ stream with the read cell, the last solve's sweep count, its final
// error and a status flag for a read outside the grid. Registers are written
// through the cfg_ channel, which is always ready and must only be used idle.
// Init runs the divider, then writes one entry of both banks per cycle; a solve
// is paced by the single read port of each bank, which fetches the five stencil
// taps of one cell in turn.
// One command is in flight at a time; the next is taken as soon as the engine
// has handed its result to the output register, even while that waits.
// Reset clears control state and restores register defaults; the banks hold
// no defined value until an init runs. A stalled m_ side holds the result
// steady and the engine waits with the next result until the register frees.

module jacobi_laplace_grid_solver #(
	parameter int MAX_GRID = jlg_pkg::MAX_GRID_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // row[6:0], col[13:7], zero fill
	input  logic [1:0]  s_tuser,   // operation[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,   // cell_value[28:0], sweeps_done[52:29], final_error[81:53]
	output logic [0:0]  m_tuser,   // status[0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [jlg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [jlg_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int ADDR_W = $clog2(MAX_GRID * MAX_GRID);
	localparam int CW     = jlg_pkg::CELL_W;

	logic [jlg_pkg::SIDE_W-1:0]  grid_size_q;
	logic [jlg_pkg::SWEEP_W-1:0] max_iter_q;
	logic [CW-1:0]               tolerance_q;
	logic                        init_mean_q;
	logic [jlg_pkg::CI_W-1:0]    check_int_q;

	jlg_pkg::cfg_t               cfg;
	jlg_pkg::cmd_t               cmd;
	jlg_pkg::res_t               res;
	logic                        res_valid;
	logic                        res_ready;
	logic [jlg_pkg::SWEEP_W-1:0] last_sweeps;
	logic [CW-1:0]               last_error;
	logic [ADDR_W-1:0]           mem_raddr;
	logic [ADDR_W-1:0]           mem_waddr;
	logic [CW-1:0]               mem_wdata;
	logic [CW-1:0]               rdata_a;
	logic [CW-1:0]               rdata_b;
	logic                        we_a;
	logic                        we_b;
	logic                        m_tvalid_q;
	logic [87:0]                 m_tdata_q;
	logic                        m_status_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_size_q <= jlg_pkg::GRID_SIZE_RST;
			max_iter_q  <= jlg_pkg::MAX_ITER_RST;
			tolerance_q <= jlg_pkg::TOL_RST;
			init_mean_q <= 1'b0;
			check_int_q <= jlg_pkg::CI_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				jlg_pkg::REG_GRID_SIZE:      grid_size_q <= cfg_data[jlg_pkg::SIDE_W-1:0];
				jlg_pkg::REG_MAX_ITERATIONS: max_iter_q  <= cfg_data[jlg_pkg::SWEEP_W-1:0];
				jlg_pkg::REG_TOLERANCE:      tolerance_q <= cfg_data[CW-1:0];
				jlg_pkg::REG_INIT_MEAN:      init_mean_q <= cfg_data[0];
				jlg_pkg::REG_CHECK_INTERVAL: check_int_q <= cfg_data[jlg_pkg::CI_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	// Clamp the side and the sweep limit
	always_comb begin
		if (grid_size_q < jlg_pkg::SIDE_W'(3)) begin
			cfg.side = jlg_pkg::SIDE_W'(3);
		end else if (int'(grid_size_q) > MAX_GRID) begin
			cfg.side = jlg_pkg::SIDE_W'(MAX_GRID);
		end else begin
			cfg.side = grid_size_q;
		end
		cfg.limit          = (max_iter_q == '0) ? jlg_pkg::SWEEP_W'(1) : max_iter_q;
		cfg.tolerance      = tolerance_q;
		cfg.init_mean      = init_mean_q;
		cfg.check_interval = check_int_q;
	end

	assign cmd.op  = jlg_pkg::op_t'(s_tuser);
	assign cmd.row = s_tdata[6:0];
	assign cmd.col = s_tdata[13:7];

	jlg_engine #(
		.MAX_GRID (MAX_GRID),
		.ADDR_W   (ADDR_W)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.cmd_valid   (s_tvalid),
		.cmd_ready   (s_tready),
		.cmd         (cmd),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res),
		.last_sweeps (last_sweeps),
		.last_error  (last_error),
		.mem_raddr   (mem_raddr),
		.rdata_a     (rdata_a),
		.rdata_b     (rdata_b),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.we_a        (we_a),
		.we_b        (we_b)
	);

	jlg_ram #(
		.DEPTH  (MAX_GRID * MAX_GRID),
		.WIDTH  (CW),
		.ADDR_W (ADDR_W)
	) u_bank_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (rdata_a)
	);

	jlg_ram #(
		.DEPTH  (MAX_GRID * MAX_GRID),
		.WIDTH  (CW),
		.ADDR_W (ADDR_W)
	) u_bank_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (rdata_b)
	);

	// Output register: take a result when empty or being drained
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			m_tdata_q  <= {6'b0, last_error, last_sweeps, res.cell_value};
			m_status_q <= res.status;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_status_q;

endmodule
